// ----- hdl/vlfn_pkg.sv -----
package vlfn_pkg;

	localparam int NAME_BYTES_DEF = 256;
	localparam int NAME_BYTES_MAX = 1024;
	// command fields are sized for the largest store
	localparam int CMD_ADDR_W = $clog2(NAME_BYTES_MAX);
	localparam int CMD_LEN_W = CMD_ADDR_W + 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int MAX_CHUNKS = 30;
	localparam int SLOT_CHARS = 13;
	localparam int WIN_BYTES = SLOT_CHARS + 1;

	localparam logic [6:0] SEQ_NONE = 7'h7F;
	localparam logic [7:0] ATTR_LFN = 8'h0F;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_DOT = 8'h2E;
	localparam logic [7:0] CHR_DELETED = 8'hE5;
	localparam int ATTR_DIR_BIT = 4;
	localparam int FIRST_SLOT_BIT = 6;

	typedef enum logic [2:0] {
		RK_SLOT_TAKEN   = 3'd0,
		RK_SLOT_CORRUPT = 3'd1,
		RK_ACCEPTED     = 3'd2,
		RK_IGNORED      = 3'd3,
		RK_CHUNK        = 3'd4
	} res_kind_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SUM,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WRITE,
		B_RD0,
		B_RD1,
		B_STATUS,
		B_CHUNK
	} back_state_t;

	typedef struct packed {
		res_kind_t                 kind;
		logic                      wr_en;
		logic [CMD_ADDR_W-1:0]     wr_start;
		logic [8*WIN_BYTES-1:0]    wr_data;
		logic [WIN_BYTES-1:0]      wr_mask;
		logic                      long_name;
		logic [CMD_LEN_W-1:0]      name_len;
		logic                      is_dir;
		logic [15:0]               cluster;
		logic [31:0]               size;
		logic [15:0]               date_word;
		logic [15:0]               time_word;
		logic [63:0]               base;
		logic [23:0]               ext;
	} cmd_t;

	typedef struct packed {
		res_kind_t   kind;
		logic        is_dir;
		logic [15:0] cluster;
		logic [31:0] size;
		logic [15:0] date_word;
		logic [15:0] time_word;
		logic [63:0] base;
		logic [23:0] ext;
		logic        has_long;
		logic [63:0] chunk;
		logic        last;
	} result_t;

	// rotate right by one, then add
	function automatic logic [7:0] ck_step(input logic [7:0] s, input logic [7:0] b);
		return {s[0], s[7:1]} + b;
	endfunction

	// entry byte holding the low half of UCS-2 character k of a slot
	function automatic logic [4:0] char_pos(input logic [3:0] k);
		logic [4:0] p;
		unique case (k)
			4'd0:  p = 5'd1;
			4'd1:  p = 5'd3;
			4'd2:  p = 5'd5;
			4'd3:  p = 5'd7;
			4'd4:  p = 5'd9;
			4'd5:  p = 5'd14;
			4'd6:  p = 5'd16;
			4'd7:  p = 5'd18;
			4'd8:  p = 5'd20;
			4'd9:  p = 5'd22;
			4'd10: p = 5'd24;
			4'd11: p = 5'd28;
			4'd12: p = 5'd30;
			default: p = 5'd1;
		endcase
		return p;
	endfunction

endpackage

// ----- hdl/vlfn_front.sv -----
module vlfn_front #(
	parameter int NAME_BYTES = vlfn_pkg::NAME_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               new_directory,
	input  logic [63:0]        entry_bytes_low,
	input  logic [63:0]        entry_bytes_mid,
	input  logic [63:0]        entry_bytes_high,
	input  logic [63:0]        entry_bytes_top,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	output logic               cmd_push,
	output vlfn_pkg::cmd_t     cmd_data,
	input  logic               cmd_full
);

	localparam int SLOTS = NAME_BYTES / 13;
	localparam logic [6:0] SLOTS_V = 7'(SLOTS);
	localparam logic [vlfn_pkg::CMD_LEN_W-1:0] NB_V = vlfn_pkg::CMD_LEN_W'(NAME_BYTES);

	vlfn_pkg::front_state_t state_q, state_d;

	logic [255:0] ent_q;
	logic         new_dir_q;
	logic [7:0]   sum_q;
	logic [6:0]   exp_q;
	logic [7:0]   ck_q;
	logic         valid_q;
	logic [5:0]   cnt_q;
	logic [15:0]  limit_q;

	logic [7:0]   eb [32];
	logic [7:0]   sum_part;
	logic [7:0]   sum_fin;

	logic [6:0]   seq0;
	logic [7:0]   ck0;
	logic         v0;
	logic         is_slot;
	logic [5:0]   seqn;
	logic         first;
	logic         in_rng;
	logic         pass;
	logic         term;
	logic [6:0]   exp1;
	logic [7:0]   ck1;
	logic         v1;
	logic [vlfn_pkg::CMD_ADDR_W-1:0] seq13;
	logic [vlfn_pkg::CMD_LEN_W-1:0]  cnt13;
	logic [15:0]  cluster;
	logic         t0, t1, t2, el0;
	logic         plain_ok;
	logic         ok;
	logic         accept;
	logic [6:0]   nxt_exp;
	logic [7:0]   nxt_ck;
	logic         nxt_valid;
	logic [5:0]   nxt_cnt;
	vlfn_pkg::cmd_t cmd;

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			eb[i] = ent_q[8*i +: 8];
		end
	end

	// checksum split in two parts: bytes 0-5 registered in F_SUM, then 6-10
	always_comb begin
		sum_part = 8'd0;
		for (int i = 0; i < 6; i++) begin
			sum_part = vlfn_pkg::ck_step(sum_part, eb[i]);
		end
		sum_fin = sum_q;
		for (int i = 6; i < 11; i++) begin
			sum_fin = vlfn_pkg::ck_step(sum_fin, eb[i]);
		end
	end

	always_comb begin
		seq0 = new_dir_q ? vlfn_pkg::SEQ_NONE : exp_q;
		ck0 = new_dir_q ? 8'd0 : ck_q;
		v0 = new_dir_q ? 1'b0 : valid_q;
		is_slot = (eb[11] == vlfn_pkg::ATTR_LFN) && (eb[12] == 8'd0) &&
			(eb[26] == 8'd0) && (eb[27] == 8'd0);
		seqn = eb[0][5:0];
		first = eb[0][vlfn_pkg::FIRST_SLOT_BIT];
		in_rng = {1'b0, seqn} < SLOTS_V;
		seq13 = vlfn_pkg::CMD_ADDR_W'(seqn) * vlfn_pkg::CMD_ADDR_W'(13);
		cnt13 = vlfn_pkg::CMD_LEN_W'(cnt_q) * vlfn_pkg::CMD_LEN_W'(13);
		cluster = {eb[27], eb[26]};

		t0 = (eb[0] == 8'd0) || (eb[0] == vlfn_pkg::CHR_SPACE);
		t1 = (eb[1] == 8'd0) || (eb[1] == vlfn_pkg::CHR_SPACE);
		t2 = (eb[2] == 8'd0) || (eb[2] == vlfn_pkg::CHR_SPACE);
		el0 = (eb[8] == 8'd0) || (eb[8] == vlfn_pkg::CHR_SPACE);
		// not free, not deleted, not "." and not ".."
		plain_ok = !t0 && (eb[0] != vlfn_pkg::CHR_DELETED) &&
			!(el0 && t1 && eb[0] == vlfn_pkg::CHR_DOT) &&
			!(el0 && !t1 && t2 && eb[0] == vlfn_pkg::CHR_DOT &&
				eb[1] == vlfn_pkg::CHR_DOT);

		exp1 = seq0;
		ck1 = ck0;
		v1 = v0;
		nxt_cnt = cnt_q;
		pass = 1'b0;
		term = 1'b0;
		ok = 1'b0;
		accept = 1'b0;
		cmd = '0;

		if (is_slot) begin
			if (first) begin
				exp1 = {1'b0, seqn};
				ck1 = eb[13];
				v1 = 1'b1;
				nxt_cnt = seqn;
			end
			term = first && in_rng;
			pass = ({1'b0, seqn} == exp1) && (eb[13] == ck1) && (seqn != 6'd0) && in_rng;
			if (!pass) begin
				v1 = 1'b0;
			end
			cmd.kind = pass ? vlfn_pkg::RK_SLOT_TAKEN : vlfn_pkg::RK_SLOT_CORRUPT;
			cmd.wr_en = pass || term;
			// passing slot: 13 chars plus terminator when first; failing first slot: terminator alone
			cmd.wr_start = pass ? (seq13 - vlfn_pkg::CMD_ADDR_W'(13)) : seq13;
			for (int k = 0; k < vlfn_pkg::SLOT_CHARS; k++) begin
				cmd.wr_data[8*k +: 8] = pass ? eb[vlfn_pkg::char_pos(4'(k))] : 8'd0;
			end
			cmd.wr_mask = pass ? {term, {vlfn_pkg::SLOT_CHARS{1'b1}}} :
				vlfn_pkg::WIN_BYTES'(1);
		end else begin
			if (seq0 != 7'd0) begin
				v1 = 1'b0;
			end
			if ((eb[11] != vlfn_pkg::ATTR_LFN) && (cluster != 16'd0)) begin
				if (v1) begin
					ok = (sum_fin == ck0);
				end else begin
					ok = plain_ok;
					if (plain_ok) begin
						cmd.wr_en = 1'b1;
						cmd.wr_mask = vlfn_pkg::WIN_BYTES'(1);
					end
				end
				accept = ok && (cluster >= 16'd2) && (cluster <= limit_q);
			end
			if (accept) begin
				cmd.kind = vlfn_pkg::RK_ACCEPTED;
				cmd.long_name = v1;
				cmd.name_len = v1 ? ((cnt13 > NB_V) ? NB_V : cnt13) : '0;
				cmd.is_dir = eb[11][vlfn_pkg::ATTR_DIR_BIT];
				cmd.cluster = cluster;
				cmd.size = {eb[31], eb[30], eb[29], eb[28]};
				cmd.date_word = {eb[25], eb[24]};
				cmd.time_word = {eb[23], eb[22]};
				cmd.base = ent_q[63:0];
				cmd.ext = {eb[10], eb[9], eb[8]};
			end else begin
				cmd.kind = vlfn_pkg::RK_IGNORED;
			end
		end

		nxt_ck = ck1;
		nxt_valid = v1;
		nxt_exp = ((exp1 == 7'd0) || (exp1 == vlfn_pkg::SEQ_NONE)) ?
			vlfn_pkg::SEQ_NONE : exp1 - 7'd1;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vlfn_pkg::F_IDLE: begin
				if (in_valid) state_d = vlfn_pkg::F_SUM;
			end
			vlfn_pkg::F_SUM: state_d = vlfn_pkg::F_PUSH;
			vlfn_pkg::F_PUSH: begin
				if (!cmd_full) state_d = vlfn_pkg::F_IDLE;
			end
			default: state_d = vlfn_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == vlfn_pkg::F_IDLE);
		cmd_push = (state_q == vlfn_pkg::F_PUSH) && !cmd_full;
		cmd_data = cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vlfn_pkg::F_IDLE;
			exp_q <= vlfn_pkg::SEQ_NONE;
			ck_q <= 8'd0;
			valid_q <= 1'b0;
			cnt_q <= 6'd0;
			limit_q <= 16'hFFFF;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (cmd_push) begin
				exp_q <= nxt_exp;
				ck_q <= nxt_ck;
				valid_q <= nxt_valid;
				cnt_q <= nxt_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ent_q <= {entry_bytes_top, entry_bytes_high, entry_bytes_mid, entry_bytes_low};
			new_dir_q <= new_directory;
		end
		if (state_q == vlfn_pkg::F_SUM) begin
			sum_q <= sum_part;
		end
	end

endmodule

// ----- hdl/vlfn_cmd_fifo.sv -----
module vlfn_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vlfn_pkg::cmd_t push_data,
	input  logic           pop,
	output vlfn_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);

	localparam int DEPTH = vlfn_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	vlfn_pkg::cmd_t store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hdl/vlfn_back.sv -----
module vlfn_back #(
	parameter int NAME_BYTES = vlfn_pkg::NAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vlfn_pkg::cmd_t    cmd_head,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output vlfn_pkg::result_t out_res
);

	localparam int ADDR_W = $clog2(NAME_BYTES);
	localparam int ROWS = (NAME_BYTES + 7) / 8;
	localparam int ROW_W = $clog2(ROWS);
	localparam int LEN_W = ADDR_W + 1;
	localparam int POS_W = (LEN_W > 8) ? LEN_W : 8;

	vlfn_pkg::back_state_t state_q, state_d;

	vlfn_pkg::cmd_t    cmd_q;
	vlfn_pkg::result_t out_q;
	vlfn_pkg::result_t out_d;
	logic              out_valid_q;
	logic [1:0]        k_q;
	logic [4:0]        c_q;
	logic [63:0]       cur_q;

	// name store: 8-byte rows, byte write enables
	logic [63:0]       mem_q [ROWS];
	logic [63:0]       rd_data_q;
	logic              mem_we;
	logic [7:0]        mem_be;
	logic [ROW_W-1:0]  mem_waddr;
	logic [63:0]       mem_wdata;
	logic              mem_re;
	logic [ROW_W-1:0]  mem_raddr;

	logic [ADDR_W-1:0] start;
	logic [191:0]      win_data;
	logic [23:0]       win_mask;
	logic [ROW_W:0]    wrow;
	logic [7:0]        rrow;

	logic              can_load;
	logic              out_load;
	logic [POS_W-1:0]  n;
	logic [POS_W-1:0]  pos_base;
	logic [7:0]        live;
	logic [63:0]       chunk;
	logic              chunk_last;
	logic              acc_long;
	logic              has_long_now;
	logic              head_long;

	assign can_load = !out_valid_q || out_ready;
	assign n = POS_W'(cmd_q.name_len);
	assign acc_long = (cmd_q.kind == vlfn_pkg::RK_ACCEPTED) && cmd_q.long_name;
	assign head_long = (cmd_head.kind == vlfn_pkg::RK_ACCEPTED) && cmd_head.long_name;
	assign has_long_now = (cur_q[7:0] != 8'd0) && (n != '0);

	assign start = cmd_q.wr_start[ADDR_W-1:0];
	assign win_data = {80'd0, cmd_q.wr_data} << {start[2:0], 3'b000};
	assign win_mask = {10'd0, cmd_q.wr_mask} << start[2:0];
	assign wrow = (ROW_W+1)'(start >> 3) + (ROW_W+1)'(k_q);
	assign rrow = {3'd0, c_q} + 8'd2;

	// chunk c: bytes up to the first zero, within the name length
	always_comb begin
		pos_base = POS_W'({c_q, 3'b000});
		for (int j = 0; j < 8; j++) begin
			live[j] = ((pos_base + POS_W'(j)) < n) && (cur_q[8*j +: 8] != 8'd0) &&
				((j == 0) ? 1'b1 : live[(j == 0) ? 0 : j-1]);
			chunk[8*j +: 8] = live[j] ? cur_q[8*j +: 8] : 8'd0;
		end
		// next row's first byte tells whether one more chunk follows
		chunk_last = !live[7] || ((pos_base + POS_W'(8)) >= n) ||
			(c_q == 5'(vlfn_pkg::MAX_CHUNKS - 1)) || (rd_data_q[7:0] == 8'd0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vlfn_pkg::B_IDLE: begin
				if (!cmd_empty) begin
					if (cmd_head.wr_en) state_d = vlfn_pkg::B_WRITE;
					else if (head_long) state_d = vlfn_pkg::B_RD0;
					else state_d = vlfn_pkg::B_STATUS;
				end
			end
			vlfn_pkg::B_WRITE: begin
				if (k_q == 2'd2) state_d = acc_long ? vlfn_pkg::B_RD0 : vlfn_pkg::B_STATUS;
			end
			vlfn_pkg::B_RD0: state_d = vlfn_pkg::B_RD1;
			vlfn_pkg::B_RD1: state_d = vlfn_pkg::B_STATUS;
			vlfn_pkg::B_STATUS: begin
				if (can_load) begin
					state_d = (acc_long && has_long_now) ? vlfn_pkg::B_CHUNK : vlfn_pkg::B_IDLE;
				end
			end
			vlfn_pkg::B_CHUNK: begin
				if (can_load && chunk_last) state_d = vlfn_pkg::B_IDLE;
			end
			default: state_d = vlfn_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		mem_we = 1'b0;
		mem_be = win_mask[8*k_q +: 8];
		mem_waddr = wrow[ROW_W-1:0];
		mem_wdata = win_data[64*k_q +: 64];
		mem_re = 1'b0;
		mem_raddr = '0;
		out_load = 1'b0;
		out_d = '0;
		unique case (state_q)
			vlfn_pkg::B_IDLE: cmd_pop = !cmd_empty;
			vlfn_pkg::B_WRITE: mem_we = 1'b1;
			vlfn_pkg::B_RD0: mem_re = 1'b1;
			vlfn_pkg::B_RD1: begin
				mem_re = 1'b1;
				mem_raddr = ROW_W'(1);
			end
			vlfn_pkg::B_STATUS: begin
				out_load = can_load;
				out_d.kind = cmd_q.kind;
				out_d.is_dir = cmd_q.is_dir;
				out_d.cluster = cmd_q.cluster;
				out_d.size = cmd_q.size;
				out_d.date_word = cmd_q.date_word;
				out_d.time_word = cmd_q.time_word;
				out_d.base = cmd_q.base;
				out_d.ext = cmd_q.ext;
				out_d.has_long = acc_long && has_long_now;
				out_d.last = !(acc_long && has_long_now);
			end
			vlfn_pkg::B_CHUNK: begin
				out_load = can_load;
				out_d.kind = vlfn_pkg::RK_CHUNK;
				out_d.chunk = chunk;
				out_d.last = chunk_last;
				mem_re = can_load && !chunk_last;
				mem_raddr = rrow[ROW_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vlfn_pkg::B_IDLE;
			out_valid_q <= 1'b0;
			k_q <= 2'd0;
			c_q <= 5'd0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd_pop) begin
				k_q <= 2'd0;
			end else if (state_q == vlfn_pkg::B_WRITE) begin
				k_q <= k_q + 2'd1;
			end
			if (state_q == vlfn_pkg::B_STATUS) begin
				c_q <= 5'd0;
			end else if (state_q == vlfn_pkg::B_CHUNK && can_load) begin
				c_q <= c_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_head;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		if ((state_q == vlfn_pkg::B_RD1) ||
			(state_q == vlfn_pkg::B_CHUNK && can_load && !chunk_last)) begin
			cur_q <= rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int j = 0; j < 8; j++) begin
				if (mem_be[j]) mem_q[mem_waddr][8*j +: 8] <= mem_wdata[8*j +: 8];
			end
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_raddr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = out_q;

endmodule

// ----- hdl/vfat_long_name_dir_entry_parser_top.sv -----
// channel   direction  handshake                 payload
// in        in         in_valid / in_ready       new_directory, entry_bytes_low..top
// out       out        out_valid / out_ready     result_kind .. name_chunk, last
// cfg       in         cfg_wr_en (no wait)       cfg_wr_data = cluster_limit
//
// Front handles an entry in turn (capture, checksum bytes 0-5, bytes 6-10 plus
// decision) and takes no new entry before it is done with the last; it stalls
// only when the 2-entry command queue is full. Back: pops a command, makes 3 row
// writes for a slot or plain-name entry, 2 store reads before an accepted long
// name, then one result per cycle (status plus up to 30 chunks) if out_ready holds.
// Reset clears sequence, checksum, valid flag and slot count and sets the limit
// to 65535; the name store is not cleared.
module vfat_long_name_dir_entry_parser_top #(
	parameter int NAME_BYTES = vlfn_pkg::NAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        new_directory,
	input  logic [63:0] entry_bytes_low,
	input  logic [63:0] entry_bytes_mid,
	input  logic [63:0] entry_bytes_high,
	input  logic [63:0] entry_bytes_top,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic        is_directory,
	output logic [15:0] start_cluster,
	output logic [31:0] file_size,
	output logic [15:0] date_word,
	output logic [15:0] time_word,
	output logic [63:0] short_base,
	output logic [23:0] short_extension,
	output logic        has_long_name,
	output logic [63:0] name_chunk,
	output logic        last
);

	vlfn_pkg::cmd_t    push_data;
	vlfn_pkg::cmd_t    head;
	vlfn_pkg::result_t res;
	logic              push, pop, full, empty;

	vlfn_front #(.NAME_BYTES(NAME_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .new_directory,
		.entry_bytes_low, .entry_bytes_mid, .entry_bytes_high, .entry_bytes_top,
		.cfg_wr_en, .cfg_wr_data,
		.cmd_push(push), .cmd_data(push_data), .cmd_full(full)
	);

	vlfn_cmd_fifo u_fifo (
		.clk, .arst_n, .push, .push_data, .pop, .head, .full, .empty
	);

	vlfn_back #(.NAME_BYTES(NAME_BYTES)) u_back (
		.clk, .arst_n, .cmd_head(head), .cmd_empty(empty), .cmd_pop(pop),
		.out_valid, .out_ready, .out_res(res)
	);

	assign result_kind = res.kind;
	assign is_directory = res.is_dir;
	assign start_cluster = res.cluster;
	assign file_size = res.size;
	assign date_word = res.date_word;
	assign time_word = res.time_word;
	assign short_base = res.base;
	assign short_extension = res.ext;
	assign has_long_name = res.has_long;
	assign name_chunk = res.chunk;
	assign last = res.last;

endmodule

// ----- hdl/vlfn_checker.sv -----
module vlfn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  result_kind,
	input logic        is_directory,
	input logic [15:0] start_cluster,
	input logic [31:0] file_size,
	input logic        has_long_name,
	input logic [63:0] name_chunk,
	input logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
			$stable(name_chunk) && $stable(last))
		else $error("result changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != vlfn_pkg::RK_ACCEPTED &&
			result_kind != vlfn_pkg::RK_CHUNK |-> last && !has_long_name)
		else $error("status transaction not final");

	a_accept_chunks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == vlfn_pkg::RK_ACCEPTED |-> last == !has_long_name)
		else $error("accepted entry last flag disagrees with long name");

	a_chunk_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == vlfn_pkg::RK_CHUNK |->
			!is_directory && start_cluster == 16'd0 && file_size == 32'd0 && !has_long_name)
		else $error("chunk carries entry fields");

endmodule

bind vfat_long_name_dir_entry_parser_top vlfn_checker u_vlfn_checker (.*);

// ----- tb/vfat_long_name_dir_entry_parser_top_test.sv -----
`timescale 1ns / 1ps

module vfat_long_name_dir_entry_parser_top_test;
	import vlfn_pkg::*;

	localparam int STORE_BYTES = NAME_BYTES_DEF;
	localparam int STORE_SLOTS = STORE_BYTES / SLOT_CHARS;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		bit           nd;
		logic [255:0] raw;
	} dir_entry_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        new_directory = 1'b0;
	logic [63:0] entry_bytes_low = '0;
	logic [63:0] entry_bytes_mid = '0;
	logic [63:0] entry_bytes_high = '0;
	logic [63:0] entry_bytes_top = '0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  result_kind;
	logic        is_directory;
	logic [15:0] start_cluster;
	logic [31:0] file_size;
	logic [15:0] date_word;
	logic [15:0] time_word;
	logic [63:0] short_base;
	logic [23:0] short_extension;
	logic        has_long_name;
	logic [63:0] name_chunk;
	logic        last;

	vfat_long_name_dir_entry_parser_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.new_directory(new_directory),
		.entry_bytes_low(entry_bytes_low), .entry_bytes_mid(entry_bytes_mid),
		.entry_bytes_high(entry_bytes_high), .entry_bytes_top(entry_bytes_top),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .is_directory(is_directory),
		.start_cluster(start_cluster), .file_size(file_size),
		.date_word(date_word), .time_word(time_word),
		.short_base(short_base), .short_extension(short_extension),
		.has_long_name(has_long_name), .name_chunk(name_chunk), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// shadow of the parser state
	logic [15:0] limit_shadow = 16'hFFFF;
	logic [6:0]  seq_shadow = SEQ_NONE;
	logic [7:0]  alias_shadow = '0;
	logic        lfn_shadow = 1'b0;
	logic [5:0]  slots_shadow = '0;
	logic [7:0]  name_mem [STORE_BYTES];

	dir_entry_t entry_q[$];
	result_t    pending_results[$];
	int         errors = 0;
	int         drive_gap_max = 4;
	int         stall_max = 4;

	int char_at [SLOT_CHARS] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

	function automatic logic [7:0] alias_sum(input logic [87:0] nm);
		logic [7:0] s;
		s = '0;
		for (int b = 0; b < 11; b++)
			s = {s[0], s[7:1]} + nm[8*b +: 8];
		return s;
	endfunction

	function automatic int name_len(input logic [7:0] p [11], input int first, input int n);
		int i;
		i = 0;
		while (i < n && p[first+i] != 8'h00 && p[first+i] != CHR_SPACE)
			i++;
		return i;
	endfunction

	function automatic void parse_entry(input dir_entry_t it);
		logic [7:0] e [32];
		logic [7:0] nm [11];
		logic [6:0] seq;
		result_t    r;
		bit         ok, acc;
		int         cl, n, len, chunks, bl, el, idx;
		logic [63:0] w;
		for (int b = 0; b < 32; b++)
			e[b] = it.raw[8*b +: 8];
		for (int b = 0; b < 11; b++)
			nm[b] = e[b];
		if (it.nd) begin
			seq_shadow = SEQ_NONE;
			alias_shadow = '0;
			lfn_shadow = 1'b0;
		end
		r = '0;
		if (e[11] == ATTR_LFN && e[12] == 8'h00 && e[26] == 8'h00 && e[27] == 8'h00) begin
			seq = {1'b0, e[0][5:0]};
			if (e[0][FIRST_SLOT_BIT]) begin
				seq_shadow = seq;
				if (seq < STORE_SLOTS)
					name_mem[seq*SLOT_CHARS] = 8'h00;
				alias_shadow = e[13];
				lfn_shadow = 1'b1;
				slots_shadow = seq[5:0];
			end
			if (seq == seq_shadow && e[13] == alias_shadow && seq != 0 && seq < STORE_SLOTS) begin
				for (int b = 0; b < SLOT_CHARS; b++)
					name_mem[(seq-1)*SLOT_CHARS + b] = e[char_at[b]];
				r.kind = RK_SLOT_TAKEN;
			end else begin
				lfn_shadow = 1'b0;
				r.kind = RK_SLOT_CORRUPT;
			end
			r.last = 1'b1;
			pending_results.push_back(r);
		end else begin
			cl = {e[27], e[26]};
			acc = 0;
			if (seq_shadow != 0)
				lfn_shadow = 1'b0;
			if (e[11] != ATTR_LFN && cl != 0) begin
				if (lfn_shadow) begin
					ok = alias_sum(it.raw[87:0]) == alias_shadow;
				end else begin
					bl = name_len(nm, 0, 8);
					el = name_len(nm, 8, 3);
					ok = !(bl == 0 || e[0] == CHR_DELETED
						|| (el == 0 && bl == 1 && e[0] == CHR_DOT)
						|| (el == 0 && bl == 2 && e[0] == CHR_DOT && e[1] == CHR_DOT));
					if (ok)
						name_mem[0] = 8'h00;
				end
				acc = ok && cl >= 2 && cl <= limit_shadow;
			end
			if (!acc) begin
				r.kind = RK_IGNORED;
				r.last = 1'b1;
				pending_results.push_back(r);
			end else begin
				len = 0;
				chunks = 0;
				if (lfn_shadow) begin
					n = slots_shadow * SLOT_CHARS;
					if (n > STORE_BYTES)
						n = STORE_BYTES;
					while (len < n && name_mem[len] != 8'h00)
						len++;
					chunks = (len + 7) / 8;
					if (chunks > MAX_CHUNKS)
						chunks = MAX_CHUNKS;
				end
				r.kind = RK_ACCEPTED;
				r.is_dir = e[11][ATTR_DIR_BIT];
				r.cluster = cl[15:0];
				r.size = {e[31], e[30], e[29], e[28]};
				r.date_word = {e[25], e[24]};
				r.time_word = {e[23], e[22]};
				r.base = it.raw[63:0];
				r.ext = it.raw[87:64];
				r.has_long = chunks != 0;
				r.last = chunks == 0;
				pending_results.push_back(r);
				for (int c = 0; c < chunks; c++) begin
					w = '0;
					for (int b = 0; b < 8; b++) begin
						idx = c*8 + b;
						if (idx < len)
							w[8*b +: 8] = name_mem[idx];
					end
					r = '0;
					r.kind = RK_CHUNK;
					r.chunk = w;
					r.last = c + 1 == chunks;
					pending_results.push_back(r);
				end
			end
		end
		if (seq_shadow == 0 || seq_shadow == SEQ_NONE)
			seq_shadow = SEQ_NONE;
		else
			seq_shadow = seq_shadow - 7'd1;
	endfunction

	// driver
	int gap_left = 0;
	int idle_cycles = 0;
	always @(posedge clk or negedge arst_n) begin
		dir_entry_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				parse_entry(dir_entry_t'{new_directory, {entry_bytes_top, entry_bytes_high,
					entry_bytes_mid, entry_bytes_low}});
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (entry_q.size() != 0) begin
					it = entry_q.pop_front();
					new_directory <= it.nd;
					{entry_bytes_top, entry_bytes_high, entry_bytes_mid, entry_bytes_low} <= it.raw;
					in_valid <= 1'b1;
					gap_left <= $urandom_range(0, drive_gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		result_t x;
		int s;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result kind %0d", result_kind);
					errors++;
				end else begin
					x = pending_results.pop_front();
					if (result_kind != x.kind) begin
						$error("result_kind exp %0d got %0d", x.kind, result_kind); errors++;
					end
					if (is_directory != x.is_dir) begin
						$error("is_directory exp %0d got %0d", x.is_dir, is_directory); errors++;
					end
					if (start_cluster != x.cluster) begin
						$error("start_cluster exp %h got %h", x.cluster, start_cluster); errors++;
					end
					if (file_size != x.size) begin
						$error("file_size exp %h got %h", x.size, file_size); errors++;
					end
					if (date_word != x.date_word) begin
						$error("date_word exp %h got %h", x.date_word, date_word); errors++;
					end
					if (time_word != x.time_word) begin
						$error("time_word exp %h got %h", x.time_word, time_word); errors++;
					end
					if (short_base != x.base) begin
						$error("short_base exp %h got %h", x.base, short_base); errors++;
					end
					if (short_extension != x.ext) begin
						$error("short_extension exp %h got %h", x.ext, short_extension); errors++;
					end
					if (has_long_name != x.has_long) begin
						$error("has_long_name exp %0d got %0d", x.has_long, has_long_name); errors++;
					end
					if (name_chunk != x.chunk) begin
						$error("name_chunk exp %h got %h", x.chunk, name_chunk); errors++;
					end
					if (last != x.last) begin
						$error("last exp %0d got %0d", x.last, last); errors++;
					end
				end
				s = $urandom_range(0, stall_max);
				stall_left <= s;
				out_ready <= s == 0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= stall_left == 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on transaction progress
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------- stimulus helpers
	function automatic logic [255:0] rand_bits();
		logic [255:0] v;
		for (int i = 0; i < 8; i++)
			v[32*i +: 32] = $urandom;
		return v;
	endfunction

	function automatic logic [15:0] rand_cluster();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'd1;
			2: return $urandom;
			default: return $urandom_range(2, 400);
		endcase
	endfunction

	function automatic logic [87:0] rand_name();
		logic [87:0] nm;
		for (int b = 0; b < 11; b++)
			nm[8*b +: 8] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
				: $urandom_range(8'h41, 8'h5A);
		return nm;
	endfunction

	function automatic logic [255:0] short_ent(input logic [87:0] nm, input logic [15:0] cl);
		logic [255:0] v;
		logic [7:0] attr;
		v = rand_bits();
		attr = $urandom_range(0, 255);
		if (attr == ATTR_LFN)
			attr = 8'h10;
		v[87:0] = nm;
		v[95:88] = attr;
		v[223:208] = cl;
		return v;
	endfunction

	// fill: 0 random chars, 1 all nonzero, 2 name ends at first char
	function automatic logic [255:0] slot_ent(input int seq, input bit first,
		input logic [7:0] ck, input int fill);
		logic [255:0] v;
		v = rand_bits();
		v[5:0] = 6'(seq);
		v[6] = first;
		v[95:88] = ATTR_LFN;
		v[103:96] = 8'h00;
		v[111:104] = ck;
		v[223:208] = 16'h0000;
		for (int b = 0; b < SLOT_CHARS; b++) begin
			if (fill == 0 && $urandom_range(0, 19) == 0)
				v[8*char_at[b] +: 8] = 8'h00;
			else
				v[8*char_at[b] +: 8] = $urandom_range(1, 255);
		end
		if (fill == 2)
			v[8*char_at[0] +: 8] = 8'h00;
		return v;
	endfunction

	task automatic add(input bit nd, input logic [255:0] v);
		entry_q.push_back('{nd, v});
	endtask

	// full long-name set: slots n..1 then the short entry; some sets broken
	task automatic add_chain(input int n, input int fill, input bit clean);
		logic [87:0] nm;
		logic [7:0] ck;
		int flaw, spot;
		nm = rand_name();
		ck = alias_sum(nm);
		flaw = clean ? 0 : ($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 4));
		spot = $urandom_range(1, n);
		for (int s = n; s >= 1; s--) begin
			if (flaw == 2 && s == spot && n > 1)
				continue;
			add(0, slot_ent(s, s == n, (flaw == 1 && s == spot) ? ~ck : ck, fill));
			if (flaw == 3 && s == spot)
				add(0, short_ent(rand_name(), rand_cluster()));
		end
		if (flaw == 4)
			nm[7:0] = nm[7:0] ^ 8'h01;
		add($urandom_range(0, 30) == 0, short_ent(nm, clean ? 16'd2 : rand_cluster()));
	endtask

	task automatic wait_idle();
		while (entry_q.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_limit(input logic [15:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		limit_shadow = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [255:0] v;
		logic [15:0] limits [6];
		int k;
		limits = '{16'hFFFF, 16'd300, 16'd0, 16'd2, 16'h0000, 16'hFFFF};
		limits[4] = $urandom_range(3, 65534);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			set_limit(limits[ph]);
			drive_gap_max = (ph % 3 == 1) ? 0 : 4;
			stall_max = (ph % 3 == 1) ? 0 : 4;
			if (ph == 0) begin
				add(0, '0);
				add(0, '1);
				v = short_ent({"TXT", "     OOF"}, 16'd2);
				v[95:88] = 8'h10;
				add(0, v);
				add(0, short_ent({"   ", "       ."}, 16'd5));
				add(0, short_ent({"   ", "      .."}, 16'd5));
				add(0, short_ent({"BIN", "     \345AB"}, 16'd7));
				add(0, short_ent({"BIN", "    ABC "}, 16'd7));
				add(0, short_ent(rand_name() | 88'h41, 16'd1));
				add(0, short_ent({"DAT", "    DATA"}, 16'd0));
				add(0, slot_ent(0, 1, 8'h11, 0));
				add(0, slot_ent(STORE_SLOTS, 1, 8'h22, 1));
				add(0, slot_ent(63, 1, 8'h33, 1));
				v = slot_ent(1, 1, 8'h44, 1);
				v[103:96] = 8'h01;
				add(0, v);
				add_chain(1, 2, 1);
				add(0, slot_ent(2, 1, 8'h55, 1));
				add(1, short_ent({"DOC", "    NOTE"}, 16'd9));
				add_chain(18, 1, 1);
			end
			k = entry_q.size();
			while (entry_q.size() - k < 64) begin
				case ($urandom_range(0, 19))
					0, 1, 2: add($urandom_range(0, 30) == 0, short_ent(rand_name(), rand_cluster()));
					3, 4: add($urandom_range(0, 3) == 0, rand_bits());
					5: add(0, slot_ent($urandom_range(0, 63), $urandom_range(0, 1), $urandom, 0));
					6: add_chain($urandom_range(1, 18), $urandom_range(0, 1), 0);
					default: add_chain($urandom_range(1, 4), 0, 0);
				endcase
			end
			wait_idle();
		end

		repeat (30) @(posedge clk);
		if (pending_results.size() != 0)
			errors++;
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
